>>> sv/nco_pkg.sv
package nco_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int PHASE_BITS_DEF  = 32;
   localparam int LUT_BITS_DEF    = 10;

   localparam int REG_BITS  = 32;
   localparam int ADDR_BITS = 3;

   typedef enum logic {
      REG_PHASE_STEP,
      REG_START_PHASE
   } reg_idx_type;

   typedef struct packed {
      logic signed [REG_BITS-1:0] phase_step;
      logic [REG_BITS-1:0]        start_phase;
   } cfg_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic so;
   } pipe_en_type;

   localparam longint Q30_ONE      = 64'sd1 << 30;
   localparam longint HALF_PI_Q30  = 64'sd1686629713;
   localparam int     TAYLOR_TERMS = 8;

   localparam longint SIN_DEN [1:TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156, 210, 272};
   localparam longint COS_DEN [1:TAYLOR_TERMS] = '{2, 12, 30, 56, 90, 132, 182, 240};

   // one table entry, {cos, sin}, each a 32-bit signed value
   function automatic logic [63:0] sincos_entry(int k, int lut_bits, int sample_bits);
      int     qb;
      int     quad;
      longint r;
      longint x;
      longint x2;
      longint ts;
      longint tc;
      longint ss;
      longint sc;
      longint amp;
      longint s;
      longint c;
      longint cv;
      longint sv;
      qb   = lut_bits - 2;
      quad = (k >> qb) & 3;
      r    = longint'(k) & ((64'sd1 << qb) - 1);
      x    = (r * HALF_PI_Q30) >>> qb;
      x2   = (x * x) / Q30_ONE;
      ts   = x;
      tc   = Q30_ONE;
      ss   = x;
      sc   = Q30_ONE;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         ts = -((ts * x2) / Q30_ONE) / SIN_DEN[n];
         tc = -((tc * x2) / Q30_ONE) / COS_DEN[n];
         ss = ss + ts;
         sc = sc + tc;
      end
      if (ss < 0) ss = 0;
      if (sc < 0) sc = 0;
      if (ss > Q30_ONE) ss = Q30_ONE;
      if (sc > Q30_ONE) sc = Q30_ONE;
      amp = (64'sd1 << (sample_bits - 1)) - 1;
      s   = (ss * amp + (64'sd1 << 29)) >>> 30;
      c   = (sc * amp + (64'sd1 << 29)) >>> 30;
      if (s > amp) s = amp;
      if (c > amp) c = amp;
      unique case (quad)
         0: begin
            cv = c;
            sv = s;
         end
         1: begin
            cv = -s;
            sv = c;
         end
         2: begin
            cv = -c;
            sv = -s;
         end
         default: begin
            cv = s;
            sv = -c;
         end
      endcase
      return {cv[31:0], sv[31:0]};
   endfunction

endpackage

>>> sv/nco_csr.sv
module nco_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [nco_pkg::ADDR_BITS-1:0] paddr,
   input  logic [nco_pkg::REG_BITS-1:0]  pwdata,
   output logic [nco_pkg::REG_BITS-1:0]  prdata,
   output logic                          pready,
   output nco_pkg::cfg_type              cfg
);
   import nco_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign reg_idx = reg_idx_type'(paddr[2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_PHASE_STEP:  cfg_in.phase_step  = pwdata;
            REG_START_PHASE: cfg_in.start_phase = pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_PHASE_STEP:  prdata = cfg_ff.phase_step;
         REG_START_PHASE: prdata = cfg_ff.start_phase;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/nco_phase.sv
module nco_phase #(
   parameter int SAMPLE_BITS = nco_pkg::SAMPLE_BITS_DEF,
   parameter int PHASE_BITS  = nco_pkg::PHASE_BITS_DEF,
   parameter int LUT_BITS    = nco_pkg::LUT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          load,
   input  logic signed [SAMPLE_BITS-1:0] in_i,
   input  logic signed [SAMPLE_BITS-1:0] in_q,
   input  logic                          frame_start,
   input  nco_pkg::cfg_type              cfg,
   output logic signed [SAMPLE_BITS-1:0] i1_ff,
   output logic signed [SAMPLE_BITS-1:0] q1_ff,
   output logic                          byp1_ff,
   output logic [LUT_BITS-1:0]           idx1_ff
);
   import nco_pkg::*;

   localparam int WIDE_BITS = PHASE_BITS + REG_BITS;

   logic [WIDE_BITS-1:0]  start_wide;
   logic [WIDE_BITS-1:0]  step_wide;
   logic [PHASE_BITS-1:0] start_al;
   logic [PHASE_BITS-1:0] step_al;
   logic [PHASE_BITS-1:0] phase_cur;
   logic [PHASE_BITS-1:0] acc_ff;
   logic [PHASE_BITS-1:0] acc_in;
   logic                  bypass;
   logic signed [SAMPLE_BITS-1:0] i1_in;
   logic signed [SAMPLE_BITS-1:0] q1_in;
   logic                  byp1_in;
   logic [LUT_BITS-1:0]   idx1_in;

   // registers count 2^-32 turn, line them up with the accumulator
   assign start_wide = {cfg.start_phase, PHASE_BITS'(0)};
   assign step_wide  = {cfg.phase_step, PHASE_BITS'(0)};
   assign start_al   = start_wide[WIDE_BITS-1 -: PHASE_BITS];
   assign step_al    = step_wide[WIDE_BITS-1 -: PHASE_BITS];
   assign bypass     = (cfg.phase_step == '0);

   assign phase_cur = frame_start ? start_al : acc_ff;

   always_comb begin
      acc_in = acc_ff;
      if (accept) begin
         acc_in = bypass ? phase_cur : phase_cur + step_al;
      end
   end

   assign i1_in   = in_i;
   assign q1_in   = in_q;
   assign byp1_in = bypass;
   assign idx1_in = phase_cur[PHASE_BITS-1 -: LUT_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         i1_ff   <= i1_in;
         q1_ff   <= q1_in;
         byp1_ff <= byp1_in;
         idx1_ff <= idx1_in;
      end
   end

endmodule

>>> sv/nco_rom.sv
module nco_rom #(
   parameter int SAMPLE_BITS = nco_pkg::SAMPLE_BITS_DEF,
   parameter int LUT_BITS    = nco_pkg::LUT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [LUT_BITS-1:0]           rd_idx,
   output logic signed [SAMPLE_BITS-1:0] cos_val,
   output logic signed [SAMPLE_BITS-1:0] sin_val
);
   import nco_pkg::*;

   localparam int TAB_SIZE = 1 << LUT_BITS;

   typedef logic [2*SAMPLE_BITS-1:0] entry_type;
   typedef entry_type rom_type [TAB_SIZE];

   function automatic rom_type build_rom();
      rom_type     t;
      logic [63:0] e;
      for (int k = 0; k < TAB_SIZE; k++) begin
         e    = sincos_entry(k, LUT_BITS, SAMPLE_BITS);
         t[k] = {e[32 +: SAMPLE_BITS], e[0 +: SAMPLE_BITS]};
      end
      return t;
   endfunction

   localparam rom_type ROM = build_rom();

   entry_type rd_data_ff;
   entry_type rd_data_in;

   assign rd_data_in = ROM[rd_idx];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rd_data_in;
      end
   end

   assign cos_val = rd_data_ff[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
   assign sin_val = rd_data_ff[SAMPLE_BITS-1:0];

endmodule

>>> sv/nco_rotate.sv
module nco_rotate #(
   parameter int SAMPLE_BITS = nco_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  nco_pkg::pipe_en_type          en,
   input  logic signed [SAMPLE_BITS-1:0] i1,
   input  logic signed [SAMPLE_BITS-1:0] q1,
   input  logic                          byp1,
   input  logic signed [SAMPLE_BITS-1:0] cos2,
   input  logic signed [SAMPLE_BITS-1:0] sin2,
   output logic signed [SAMPLE_BITS-1:0] out_i,
   output logic signed [SAMPLE_BITS-1:0] out_q
);
   import nco_pkg::*;

   localparam int PW = 2 * SAMPLE_BITS;
   localparam int SW = PW + 2;
   localparam int RW = SAMPLE_BITS + 3;
   localparam logic signed [SW-1:0] RND = SW'(64'sd1 <<< (SAMPLE_BITS - 2));

   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(logic signed [SW-1:0] t);
      logic signed [RW-1:0] r;
      logic [3:0]           top;
      r   = t[SW-1:SAMPLE_BITS-1];
      top = r[RW-1:SAMPLE_BITS-1];
      if ((&top) || !(|top)) begin
         return r[SAMPLE_BITS-1:0];
      end
      return {r[RW-1], {(SAMPLE_BITS-1){~r[RW-1]}}};
   endfunction

   logic signed [SAMPLE_BITS-1:0] i2_ff, q2_ff, i3_ff, q3_ff;
   logic                          byp2_ff, byp3_ff;
   logic signed [PW-1:0]          ic_ff, qs_ff, is_ff, qc_ff;
   logic signed [PW-1:0]          ic_in, qs_in, is_in, qc_in;
   logic signed [SW-1:0]          sum_i, sum_q;
   logic signed [SAMPLE_BITS-1:0] out_i_ff, out_q_ff, out_i_in, out_q_in;

   assign ic_in = i2_ff * cos2;
   assign qs_in = q2_ff * sin2;
   assign is_in = i2_ff * sin2;
   assign qc_in = q2_ff * cos2;

   assign sum_i = SW'(ic_ff) - SW'(qs_ff) + RND;
   assign sum_q = SW'(is_ff) + SW'(qc_ff) + RND;

   assign out_i_in = byp3_ff ? i3_ff : round_sat(sum_i);
   assign out_q_in = byp3_ff ? q3_ff : round_sat(sum_q);

   always_ff @(posedge clock) begin
      if (en.s2) begin
         i2_ff   <= i1;
         q2_ff   <= q1;
         byp2_ff <= byp1;
      end
      if (en.s3) begin
         ic_ff   <= ic_in;
         qs_ff   <= qs_in;
         is_ff   <= is_in;
         qc_ff   <= qc_in;
         i3_ff   <= i2_ff;
         q3_ff   <= q2_ff;
         byp3_ff <= byp2_ff;
      end
      if (en.so) begin
         out_i_ff <= out_i_in;
         out_q_ff <= out_q_in;
      end
   end

   assign out_i = out_i_ff;
   assign out_q = out_q_ff;

endmodule

>>> sv/nco_frequency_offset_mixer.sv
// Complex NCO mixer: rotates a Q1.15 I/Q stream by a running phase.
// Input channel req_*: one sample per transaction, with req_frame_start
// reloading the phase accumulator with start_phase for that sample.
// Result channel rsp_*: one rotated, rounded and saturated sample for every
// input transaction, in order.
// Register port (APB): phase_step at byte address 0, start_phase at 4.
// A zero phase_step passes samples through unchanged.
// A sample passes through the input register, the table read, the
// multipliers and the output register before it appears on rsp_*.
// Throughput: one transaction per clock while rsp_stall is low; the limit
// is the single pipeline slot per stage, with the table read and the four
// multipliers each taking one registered stage.
// Reset clears the registers, the phase accumulator and all stage valids.
// When rsp_stall is high the output holds; stages behind it keep filling
// empty slots, and req_stall rises only once every stage holds a sample.
module nco_frequency_offset_mixer #(
   parameter int SAMPLE_BITS = nco_pkg::SAMPLE_BITS_DEF,
   parameter int PHASE_BITS  = nco_pkg::PHASE_BITS_DEF,
   parameter int LUT_BITS    = nco_pkg::LUT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_in_i,
   input  logic signed [SAMPLE_BITS-1:0] req_in_q,
   input  logic                          req_frame_start,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_i,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_q,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [nco_pkg::ADDR_BITS-1:0] paddr,
   input  logic [nco_pkg::REG_BITS-1:0]  pwdata,
   output logic [nco_pkg::REG_BITS-1:0]  prdata,
   output logic                          pready
);
   import nco_pkg::*;

   cfg_type     cfg;
   pipe_en_type en;
   logic        accept;
   logic        v1_ff, v2_ff, v3_ff, vo_ff;
   logic        v1_in, v2_in, v3_in, vo_in;

   logic signed [SAMPLE_BITS-1:0] i1, q1, cos2, sin2;
   logic                          byp1;
   logic [LUT_BITS-1:0]           idx1;

   assign en.so = !vo_ff || !rsp_stall;
   assign en.s3 = !v3_ff || en.so;
   assign en.s2 = !v2_ff || en.s3;
   assign en.s1 = !v1_ff || en.s2;

   assign req_stall = !en.s1;
   assign accept    = req_valid && en.s1;

   assign v1_in = en.s1 ? req_valid : v1_ff;
   assign v2_in = en.s2 ? v1_ff : v2_ff;
   assign v3_in = en.s3 ? v2_ff : v3_ff;
   assign vo_in = en.so ? v3_ff : vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   assign rsp_valid = vo_ff;

   nco_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   nco_phase #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PHASE_BITS  (PHASE_BITS),
      .LUT_BITS    (LUT_BITS)
   ) u_phase (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .load        (en.s1),
      .in_i        (req_in_i),
      .in_q        (req_in_q),
      .frame_start (req_frame_start),
      .cfg         (cfg),
      .i1_ff       (i1),
      .q1_ff       (q1),
      .byp1_ff     (byp1),
      .idx1_ff     (idx1)
   );

   nco_rom #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .LUT_BITS    (LUT_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (en.s2),
      .rd_idx  (idx1),
      .cos_val (cos2),
      .sin_val (sin2)
   );

   nco_rotate #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_rotate (
      .clock (clock),
      .en    (en),
      .i1    (i1),
      .q1    (q1),
      .byp1  (byp1),
      .cos2  (cos2),
      .sin2  (sin2),
      .out_i (rsp_out_i),
      .out_q (rsp_out_q)
   );

endmodule

>>> tb/nco_mix_checker.sv
`timescale 1ns / 1ps

module nco_mix_checker
   import nco_pkg::*;
(
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [SAMPLE_BITS_DEF-1:0]     req_in_i,
   input  logic signed [SAMPLE_BITS_DEF-1:0]     req_in_q,
   input  logic                                  req_frame_start,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [SAMPLE_BITS_DEF-1:0]     rsp_out_i,
   input  logic signed [SAMPLE_BITS_DEF-1:0]     rsp_out_q,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ADDR_BITS-1:0]                  paddr,
   input  logic [REG_BITS-1:0]                   pwdata,
   input  logic                                  pready,
   output int                                    outstanding,
   output int                                    errors,
   output int                                    clipped
);

   localparam int     SAMPLE_W = SAMPLE_BITS_DEF;
   localparam int     PHASE_W  = PHASE_BITS_DEF;
   localparam int     LUT_W    = LUT_BITS_DEF;
   localparam int     LUT_SIZE = 1 << LUT_W;
   localparam longint ONE_Q30  = 64'sd1 << 30;
   localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
   localparam longint AMP      = (64'sd1 << (SAMPLE_W - 1)) - 1;
   localparam longint OUT_MAX  = (64'sd1 << (SAMPLE_W - 1)) - 1;
   localparam longint OUT_MIN  = -(64'sd1 << (SAMPLE_W - 1));

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] i;
      logic signed [SAMPLE_W-1:0] q;
   } mix_pair;

   longint          cos_lut [LUT_SIZE];
   longint          sin_lut [LUT_SIZE];
   logic [31:0]     step_reg;
   logic [31:0]     start_reg;
   logic [PHASE_W-1:0] nco_phase;
   mix_pair         expected_mix [$];

   initial begin
      errors  = 0;
      clipped = 0;
      outstanding = 0;
   end

   // quarter-wave sin/cos by truncated taylor series, q30 fixed point
   task automatic quarter_wave(input longint x, output longint s_out, output longint c_out);
      longint x2;
      longint ts;
      longint tc;
      x2 = (x * x) / ONE_Q30;
      ts = x;
      tc = ONE_Q30;
      s_out = x;
      c_out = ONE_Q30;
      for (int n = 1; n <= 8; n++) begin
         ts = -((ts * x2) / ONE_Q30) / longint'((2 * n) * (2 * n + 1));
         tc = -((tc * x2) / ONE_Q30) / longint'((2 * n - 1) * (2 * n));
         s_out = s_out + ts;
         c_out = c_out + tc;
      end
      if (s_out < 0) s_out = 0;
      if (c_out < 0) c_out = 0;
      if (s_out > ONE_Q30) s_out = ONE_Q30;
      if (c_out > ONE_Q30) c_out = ONE_Q30;
   endtask

   function automatic longint to_amplitude(input longint v);
      longint r;
      r = (v * AMP + (64'sd1 << 29)) / ONE_Q30;
      return (r > AMP) ? AMP : r;
   endfunction

   initial begin
      int     quarter;
      longint x;
      longint s64;
      longint c64;
      longint s;
      longint c;
      quarter = LUT_SIZE / 4;
      for (int k = 0; k < LUT_SIZE; k++) begin
         x = (longint'(k % quarter) * QUARTER_TURN_Q30) / longint'(quarter);
         quarter_wave(x, s64, c64);
         s = to_amplitude(s64);
         c = to_amplitude(c64);
         case (k / quarter)
            0: begin
               cos_lut[k] = c;
               sin_lut[k] = s;
            end
            1: begin
               cos_lut[k] = -s;
               sin_lut[k] = c;
            end
            2: begin
               cos_lut[k] = -c;
               sin_lut[k] = -s;
            end
            default: begin
               cos_lut[k] = s;
               sin_lut[k] = -c;
            end
         endcase
      end
   end

   // round half up, then clamp to the signed sample range
   function automatic logic signed [SAMPLE_W-1:0] round_clip(input longint prod_sum);
      longint r;
      r = (prod_sum + (64'sd1 << (SAMPLE_W - 2))) >>> (SAMPLE_W - 1);
      if (r > OUT_MAX) begin
         r = OUT_MAX;
         clipped++;
      end else if (r < OUT_MIN) begin
         r = OUT_MIN;
         clipped++;
      end
      return r[SAMPLE_W-1:0];
   endfunction

   function automatic mix_pair mix_sample(input logic signed [SAMPLE_W-1:0] xi,
                                          input logic signed [SAMPLE_W-1:0] xq,
                                          input logic fs);
      mix_pair          y;
      logic [LUT_W-1:0] idx;
      longint           c;
      longint           s;
      if (fs) nco_phase = start_reg;
      if (step_reg == '0) begin
         y.i = xi;
         y.q = xq;
      end else begin
         idx = nco_phase[PHASE_W-1 -: LUT_W];
         c = cos_lut[idx];
         s = sin_lut[idx];
         y.i = round_clip(longint'(xi) * c - longint'(xq) * s);
         y.q = round_clip(longint'(xi) * s + longint'(xq) * c);
         nco_phase = nco_phase + step_reg;
      end
      return y;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      mix_pair want;
      if (reset) begin
         expected_mix.delete();
         step_reg  = '0;
         start_reg = '0;
         nco_phase = '0;
      end else begin
         if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
            case (reg_idx_type'(paddr[2]))
               REG_PHASE_STEP:  step_reg  = pwdata;
               REG_START_PHASE: start_reg = pwdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_mix.size() == 0) begin
               report_mismatch("unexpected transaction, out_i", int'(rsp_out_i), 0);
            end else begin
               want = expected_mix.pop_front();
               if (rsp_out_i !== want.i) report_mismatch("out_i", int'(rsp_out_i), int'(want.i));
               if (rsp_out_q !== want.q) report_mismatch("out_q", int'(rsp_out_q), int'(want.q));
            end
         end
         if (req_valid && !req_stall)
            expected_mix.push_back(mix_sample(req_in_i, req_in_q, req_frame_start));
      end
      outstanding <= expected_mix.size();
   end

endmodule

>>> tb/tb_nco_frequency_offset_mixer.sv
`timescale 1ns / 1ps

module tb_nco_frequency_offset_mixer;
   import nco_pkg::*;

   localparam int SAMPLE_W    = SAMPLE_BITS_DEF;
   localparam int CYCLE_LIMIT = 300000;

   logic                        clock;
   logic                        reset           = 1'b1;
   logic                        req_valid       = 1'b0;
   logic                        req_stall;
   logic signed [SAMPLE_W-1:0]  req_in_i        = '0;
   logic signed [SAMPLE_W-1:0]  req_in_q        = '0;
   logic                        req_frame_start = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall       = 1'b0;
   logic signed [SAMPLE_W-1:0]  rsp_out_i;
   logic signed [SAMPLE_W-1:0]  rsp_out_q;
   logic                        psel            = 1'b0;
   logic                        penable         = 1'b0;
   logic                        pwrite          = 1'b0;
   logic [ADDR_BITS-1:0]        paddr           = '0;
   logic [REG_BITS-1:0]         pwdata          = '0;
   logic [REG_BITS-1:0]         prdata;
   logic                        pready;

   int outstanding;
   int errors;
   int clipped;
   int cycle_count   = 0;
   int sample_count  = 0;
   int frame_count   = 0;
   int setting_count = 0;
   int rsp_count     = 0;

   nco_frequency_offset_mixer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_i        (req_in_i),
      .req_in_q        (req_in_q),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_i       (rsp_out_i),
      .rsp_out_q       (rsp_out_q),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   nco_mix_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_i        (req_in_i),
      .req_in_q        (req_in_q),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_i       (rsp_out_i),
      .rsp_out_q       (rsp_out_q),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .outstanding     (outstanding),
      .errors          (errors),
      .clipped         (clipped)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // entered and left at a rising edge
   task automatic csr_write(input reg_idx_type idx, input logic [REG_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (pready !== 1'b1) @(negedge clock);
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering and wait for every pending result
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [31:0] step, input logic [31:0] start);
      drain();
      csr_write(REG_PHASE_STEP, step);
      csr_write(REG_START_PHASE, start);
      setting_count++;
   endtask

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] xi,
                              input logic signed [SAMPLE_W-1:0] xq,
                              input logic fs, input int gap_max);
      int gap;
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_in_i        <= xi;
      req_in_q        <= xq;
      req_frame_start <= fs;
      @(negedge clock);
      while (req_stall !== 1'b0) @(negedge clock);
      @(posedge clock);
      sample_count++;
      if (fs) frame_count++;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(11, 0))
         0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
         1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_step();
      case ($urandom_range(6, 0))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         3: return 32'($urandom_range(65535, 1));
         4: return -32'($urandom_range(65535, 1));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_start();
      case ($urandom_range(3, 0))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // result side: random stall per transaction, stall-free stretches, plus two long hold-offs
   initial begin
      int w;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_count == 300 || rsp_count == 900) w = 40;
         else if ((rsp_count / 200) % 3 == 2) w = 0;
         else w = $urandom_range(4, 0);
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
         while (rsp_valid !== 1'b1) @(negedge clock);
         @(posedge clock);
         rsp_count++;
      end
   end

   initial begin
      int gap_max;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bypass straight out of reset
      send_sample(16'sh7fff, 16'sh8000, 1'b0, 0);
      send_sample(16'sh8000, 16'sh7fff, 1'b1, 0);
      send_sample(16'sh0000, 16'shffff, 1'b0, 2);
      send_sample(16'shffff, 16'sh0000, 1'b0, 0);

      // phase counts from zero before any frame start
      drain();
      csr_write(REG_PHASE_STEP, 32'h1000_0000);
      setting_count++;
      send_sample(16'sh4000, 16'shc000, 1'b0, 0);
      send_sample(16'sh7fff, 16'sh7fff, 1'b0, 0);
      send_sample(16'sh8000, 16'sh8000, 1'b0, 1);
      send_sample(16'sh0001, 16'shffff, 1'b0, 0);

      // eighth turn: full-scale inputs clip
      apply_setting(32'h0000_0001, 32'h2000_0000);
      send_sample(16'sh7fff, 16'sh7fff, 1'b1, 0);
      send_sample(16'sh8000, 16'sh8000, 1'b1, 0);
      send_sample(16'sh7fff, 16'sh8000, 1'b1, 0);
      send_sample(16'sh8000, 16'sh7fff, 1'b1, 0);

      // half-turn step, phase wraps past the top
      apply_setting(32'h8000_0000, 32'hffff_ffff);
      send_sample(16'sh3039, -16'sd23456, 1'b1, 0);
      send_sample(16'sh8000, 16'sh7fff, 1'b0, 0);
      send_sample(16'sh7fff, 16'sh7fff, 1'b0, 0);
      send_sample(16'shffff, 16'sh0001, 1'b0, 0);

      apply_setting(32'h7fff_ffff, 32'hffff_ffff);
      send_sample(16'sh7fff, 16'sh8000, 1'b1, 0);
      send_sample(16'sd20000, 16'sd20000, 1'b0, 0);
      send_sample(-16'sd20000, 16'sd5, 1'b0, 0);

      // negative step wraps below zero
      apply_setting(32'hffff_ffff, 32'h0000_0000);
      send_sample(16'sh7fff, 16'sh0000, 1'b1, 0);
      send_sample(16'sh0000, 16'sh7fff, 1'b0, 0);
      send_sample(16'sh8000, 16'sh0000, 1'b0, 0);

      for (int p = 0; p < 8; p++) begin
         apply_setting(pick_step(), pick_start());
         gap_max = (p % 3 == 1) ? 0 : 4;
         for (int n = 0; n < 165; n++) begin
            if (n == 80) drain();
            send_sample(pick_sample(), pick_sample(),
                        n == 0 || $urandom_range(15, 0) == 0, gap_max);
         end
      end

      drain();
      repeat (12) @(posedge clock);
      $display("run: %0d samples, %0d frame starts, %0d register settings",
               sample_count, frame_count, setting_count);
      $display("run: %0d results checked, %0d clipped outputs", rsp_count, clipped);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
